@@ hw/rtl/tkac_pkg.sv @@
package tkac_pkg;

   localparam int MAX_CLASSES_DEF = 8;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int NUM_SCORES   = 8;
   localparam int SCORE_W      = 16;
   localparam int LABEL_W      = 8;
   localparam int ENTRY_W      = 4;
   localparam int RPT_W        = 32;
   localparam int GATE_W       = 20;
   localparam int SAMPLE_W     = 10;
   localparam int ADDR_W       = 5;

   localparam logic [GATE_W-1:0]   GATE_MAX   = '1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   // floor(x/3) = (x*683) >> 11 for any 10-bit x
   localparam logic [GATE_W-1:0] DIV3_RECIP = 20'd683;
   localparam int                DIV3_SHIFT = 11;

   localparam logic [2:0] REG_TOP_K       = 3'd0;
   localparam logic [2:0] REG_NUM_CLASSES = 3'd1;
   localparam logic [2:0] REG_IGNORE_EN   = 3'd2;
   localparam logic [2:0] REG_IGNORE_LBL  = 3'd3;
   localparam logic [2:0] REG_SAMPLES     = 3'd4;
   localparam logic [2:0] REG_THRESHOLD   = 3'd5;

   typedef logic signed [SCORE_W-1:0] score_type;

endpackage

@@ hw/rtl/tkac_rank.sv @@
module tkac_rank
   import tkac_pkg::*;
#(
   parameter int MAX_CLASSES = MAX_CLASSES_DEF,
   parameter int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
   parameter int CLS_W = $clog2(MAX_CLASSES + 1)
) (
   input  score_type        scores [NUM_SCORES],
   input  logic [IDX_W-1:0] label,
   input  logic [CLS_W-1:0] ncls,
   input  logic [3:0]       top_k,
   output logic             hit
);

   logic [MAX_CLASSES-1:0] beats;
   logic [CLS_W-1:0]       rank;
   score_type              ref_score;

   assign ref_score = scores[label];

   always_comb begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
         beats[c] = (CLS_W'(c) < ncls) &&
                    ((scores[c] > ref_score) ||
                     ((scores[c] == ref_score) && (IDX_W'(c) > label)));
      end
   end

   assign rank = CLS_W'($countones(beats));
   assign hit  = 4'(rank) < top_k;

endmodule

@@ hw/rtl/topk_accuracy_counter.sv @@
// An accepted word goes into the input register, then updates the counters; a batch_end
//   word fills the report buffer, which drains one report word per cycle unless rsp_stall holds it.
// Throughput: one word per cycle; a batch_end word waits in the input register while
//   the previous report (1 + num_classes words) is still draining.
// Reset: synchronous, active high; clears counters, report state, and loads the
//   register reset values. No clearing pass.
module topk_accuracy_counter
   import tkac_pkg::*;
#(
   parameter int MAX_CLASSES = MAX_CLASSES_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LABEL_W-1:0]  req_true_label,
   input  logic [SCORE_W-1:0]  req_score_0,
   input  logic [SCORE_W-1:0]  req_score_1,
   input  logic [SCORE_W-1:0]  req_score_2,
   input  logic [SCORE_W-1:0]  req_score_3,
   input  logic [SCORE_W-1:0]  req_score_4,
   input  logic [SCORE_W-1:0]  req_score_5,
   input  logic [SCORE_W-1:0]  req_score_6,
   input  logic [SCORE_W-1:0]  req_score_7,
   input  logic                req_sample_end,
   input  logic                req_batch_end,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [RPT_W-1:0]    rsp_hit_count,
   output logic [RPT_W-1:0]    rsp_total_count,
   output logic                rsp_report_last,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int IDX_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CLS_W  = $clog2(MAX_CLASSES + 1);
   localparam int ENT    = MAX_CLASSES + 1;
   localparam int LEFT_W = $clog2(ENT + 1);

   typedef logic [COUNT_WIDTH-1:0] cnt_type;

   function automatic cnt_type sat_add(input cnt_type a, input cnt_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [RPT_W-1:0] to_rpt(input cnt_type v);
      logic [63:0] w;
      w = 64'(v);
      return (w[63:32] != 32'd0) ? '1 : w[31:0];
   endfunction

   // configuration
   logic [3:0]          top_k_ff, ncls_cfg_ff;
   logic                ign_en_ff;
   logic [LABEL_W-1:0]  ign_lbl_ff;
   logic [SAMPLE_W-1:0] spb_ff, gate_len_ff;
   logic [GATE_W-1:0]   thr_ff, spb_x;
   logic                cfg_wr;
   logic [2:0]          cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         top_k_ff    <= 4'd1;
         ncls_cfg_ff <= 4'd5;
         ign_en_ff   <= 1'b0;
         ign_lbl_ff  <= 8'd255;
         spb_ff      <= 10'd3;
         thr_ff      <= 20'd8192;
         gate_len_ff <= '0;
      end else begin
         gate_len_ff <= SAMPLE_W'(((spb_x * DIV3_RECIP) >> DIV3_SHIFT) << 1);
         if (cfg_wr) begin
            unique case (cfg_idx)
               REG_TOP_K:       top_k_ff    <= pwdata[3:0];
               REG_NUM_CLASSES: ncls_cfg_ff <= pwdata[3:0];
               REG_IGNORE_EN:   ign_en_ff   <= pwdata[0];
               REG_IGNORE_LBL:  ign_lbl_ff  <= pwdata[LABEL_W-1:0];
               REG_SAMPLES:     spb_ff      <= pwdata[SAMPLE_W-1:0];
               REG_THRESHOLD:   thr_ff      <= pwdata[GATE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign spb_x = GATE_W'(spb_ff);

   always_comb begin
      unique case (cfg_idx)
         REG_TOP_K:       prdata = 32'(top_k_ff);
         REG_NUM_CLASSES: prdata = 32'(ncls_cfg_ff);
         REG_IGNORE_EN:   prdata = 32'(ign_en_ff);
         REG_IGNORE_LBL:  prdata = 32'(ign_lbl_ff);
         REG_SAMPLES:     prdata = 32'(spb_ff);
         REG_THRESHOLD:   prdata = 32'(thr_ff);
         default:         prdata = '0;
      endcase
   end

   // input register
   logic               s1_valid_ff, s1_valid_in;
   logic [LABEL_W-1:0] s1_label_ff;
   score_type          s1_score_ff [NUM_SCORES];
   logic               s1_send_ff, s1_bend_ff;
   logic               req_take, s1_go, rpt_busy;
   logic [LEFT_W-1:0]  rpt_left_ff;

   assign rpt_busy  = rpt_left_ff != '0;
   assign s1_go     = s1_valid_ff && !(s1_bend_ff && rpt_busy);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)   s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_label_ff    <= req_true_label;
         s1_score_ff[0] <= req_score_0;
         s1_score_ff[1] <= req_score_1;
         s1_score_ff[2] <= req_score_2;
         s1_score_ff[3] <= req_score_3;
         s1_score_ff[4] <= req_score_4;
         s1_score_ff[5] <= req_score_5;
         s1_score_ff[6] <= req_score_6;
         s1_score_ff[7] <= req_score_7;
         s1_send_ff     <= req_sample_end || req_batch_end;
         s1_bend_ff     <= req_batch_end;
      end
   end

   // pixel classification
   logic [CLS_W-1:0]    ncls;
   logic                gated, counted, hit, keep;
   logic [LABEL_W-1:0]  label;
   logic [IDX_W-1:0]    label_idx;
   logic [SAMPLE_W-1:0] sample_cnt_ff, sample_cnt_in;

   assign ncls  = (ncls_cfg_ff > 4'(MAX_CLASSES)) ? CLS_W'(MAX_CLASSES) : CLS_W'(ncls_cfg_ff);
   assign gated = sample_cnt_ff < gate_len_ff;

   always_comb begin
      label = s1_label_ff;
      if (gated) begin
         case (s1_label_ff) inside
            8'd0, 8'd1, 8'd2, 8'd4: label = 8'd0;
            8'd3:                   label = 8'd1;
            default:                label = s1_label_ff;
         endcase
      end
   end

   assign counted   = !(ign_en_ff && (label == ign_lbl_ff)) && (label < LABEL_W'(ncls));
   assign label_idx = label[IDX_W-1:0];

   tkac_rank #(
      .MAX_CLASSES(MAX_CLASSES),
      .IDX_W(IDX_W),
      .CLS_W(CLS_W)
   ) u_rank (
      .scores(s1_score_ff),
      .label(label_idx),
      .ncls(ncls),
      .top_k(top_k_ff),
      .hit(hit)
   );

   // counters
   logic [GATE_W-1:0]   gate_cnt_ff, gate_cnt_in;
   cnt_type             pend_hit_ff, pend_hit_in, pend_tot_ff, pend_tot_in;
   cnt_type             kept_hit_ff, kept_hit_in, kept_tot_ff, kept_tot_in;
   cnt_type             pc_hit_ff [MAX_CLASSES], pc_hit_in [MAX_CLASSES];
   cnt_type             pc_tot_ff [MAX_CLASSES], pc_tot_in [MAX_CLASSES];
   cnt_type             kc_hit_ff [MAX_CLASSES], kc_hit_in [MAX_CLASSES];
   cnt_type             kc_tot_ff [MAX_CLASSES], kc_tot_in [MAX_CLASSES];
   logic                snap;

   assign snap = s1_go && s1_bend_ff;

   always_comb begin
      sample_cnt_in = sample_cnt_ff;
      gate_cnt_in   = gate_cnt_ff;
      pend_hit_in   = pend_hit_ff;
      pend_tot_in   = pend_tot_ff;
      kept_hit_in   = kept_hit_ff;
      kept_tot_in   = kept_tot_ff;
      pc_hit_in     = pc_hit_ff;
      pc_tot_in     = pc_tot_ff;
      kc_hit_in     = kc_hit_ff;
      kc_tot_in     = kc_tot_ff;
      keep          = 1'b0;
      if (s1_go) begin
         if (gated && ((s1_label_ff == 8'd1) || (s1_label_ff == 8'd3)) &&
             (gate_cnt_ff != GATE_MAX)) begin
            gate_cnt_in = gate_cnt_ff + 1'b1;
         end
         if (counted) begin
            pend_tot_in = sat_add(pend_tot_ff, cnt_type'(1));
            if (hit) pend_hit_in = sat_add(pend_hit_ff, cnt_type'(1));
         end
         for (int c = 0; c < MAX_CLASSES; c++) begin
            if (counted && (label_idx == IDX_W'(c))) begin
               pc_tot_in[c] = sat_add(pc_tot_ff[c], cnt_type'(1));
               if (hit) pc_hit_in[c] = sat_add(pc_hit_ff[c], cnt_type'(1));
            end
         end
         if (s1_send_ff) begin
            keep = !gated || (gate_cnt_in >= thr_ff);
            if (keep) begin
               kept_hit_in = sat_add(kept_hit_ff, pend_hit_in);
               kept_tot_in = sat_add(kept_tot_ff, pend_tot_in);
               for (int c = 0; c < MAX_CLASSES; c++) begin
                  kc_hit_in[c] = sat_add(kc_hit_ff[c], pc_hit_in[c]);
                  kc_tot_in[c] = sat_add(kc_tot_ff[c], pc_tot_in[c]);
               end
            end
            pend_hit_in = '0;
            pend_tot_in = '0;
            for (int c = 0; c < MAX_CLASSES; c++) begin
               pc_hit_in[c] = '0;
               pc_tot_in[c] = '0;
            end
            gate_cnt_in = '0;
            if (sample_cnt_ff != SAMPLE_MAX) sample_cnt_in = sample_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_cnt_ff <= '0;
         gate_cnt_ff   <= '0;
         pend_hit_ff   <= '0;
         pend_tot_ff   <= '0;
         kept_hit_ff   <= '0;
         kept_tot_ff   <= '0;
         for (int c = 0; c < MAX_CLASSES; c++) begin
            pc_hit_ff[c] <= '0;
            pc_tot_ff[c] <= '0;
            kc_hit_ff[c] <= '0;
            kc_tot_ff[c] <= '0;
         end
      end else begin
         sample_cnt_ff <= snap ? '0 : sample_cnt_in;
         gate_cnt_ff   <= gate_cnt_in;
         pend_hit_ff   <= pend_hit_in;
         pend_tot_ff   <= pend_tot_in;
         kept_hit_ff   <= snap ? '0 : kept_hit_in;
         kept_tot_ff   <= snap ? '0 : kept_tot_in;
         pc_hit_ff     <= pc_hit_in;
         pc_tot_ff     <= pc_tot_in;
         for (int c = 0; c < MAX_CLASSES; c++) begin
            kc_hit_ff[c] <= snap ? '0 : kc_hit_in[c];
            kc_tot_ff[c] <= snap ? '0 : kc_tot_in[c];
         end
      end
   end

   // report buffer, drained front first
   logic [RPT_W-1:0]   rb_hit_ff [ENT];
   logic [RPT_W-1:0]   rb_tot_ff [ENT];
   logic [ENTRY_W-1:0] rpt_idx_ff;
   logic               out_load;

   assign out_load = rpt_busy && (!rsp_valid || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_left_ff <= '0;
         rpt_idx_ff  <= '0;
      end else if (snap) begin
         rpt_left_ff <= LEFT_W'(ncls) + 1'b1;
         rpt_idx_ff  <= '0;
      end else if (out_load) begin
         rpt_left_ff <= rpt_left_ff - 1'b1;
         rpt_idx_ff  <= rpt_idx_ff + 1'b1;
      end
      if (snap) begin
         rb_hit_ff[0] <= to_rpt(kept_hit_in);
         rb_tot_ff[0] <= to_rpt(kept_tot_in);
         for (int c = 0; c < MAX_CLASSES; c++) begin
            rb_hit_ff[c+1] <= to_rpt(kc_hit_in[c]);
            rb_tot_ff[c+1] <= to_rpt(kc_tot_in[c]);
         end
      end else if (out_load) begin
         for (int e = 0; e < ENT - 1; e++) begin
            rb_hit_ff[e] <= rb_hit_ff[e+1];
            rb_tot_ff[e] <= rb_tot_ff[e+1];
         end
      end
   end

   // output register
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_entry_index <= rpt_idx_ff;
         rsp_hit_count   <= rb_hit_ff[0];
         rsp_total_count <= rb_tot_ff[0];
         rsp_report_last <= rpt_left_ff == LEFT_W'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_hit_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_count <= rsp_total_count))
      else $error("report word has more hits than total");

   a_report_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_report_last) |=>
      (rsp_valid && (rsp_entry_index == $past(rsp_entry_index) + 1'b1)))
      else $error("report words not back to back");

   a_stall_only_on_report: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_bend_ff && rpt_busy))
      else $error("input stalled without a pending report");

   a_snap_idle: assert property (@(posedge clock) disable iff (reset)
      snap |=> (rpt_left_ff == LEFT_W'($past(ncls)) + 1'b1))
      else $error("report length wrong");

endmodule
